/* rtl/brcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package brcp_pkg;

  // Port field widths
  localparam int unsigned GAIN_W      = 32;
  localparam int unsigned ILIM_W      = 16;
  localparam int unsigned ANGLE_W     = 17;
  localparam int unsigned PWM_W       = 15;
  localparam int unsigned SMAX_W      = 7;
  localparam int unsigned ENC_W       = 16;
  localparam int unsigned GYRO_W      = 16;
  localparam int unsigned MOTOR_W     = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_KD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_KP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ANGLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_LIMIT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX      = 3'd7;

  // Register reset values
  localparam logic signed [GAIN_W-1:0]  UPRIGHT_KP_RST     = -32'sd19660800;
  localparam logic signed [GAIN_W-1:0]  UPRIGHT_KD_RST     = -32'sd79954;
  localparam logic signed [GAIN_W-1:0]  SPEED_KP_RST       = 32'sd29491;
  localparam logic signed [GAIN_W-1:0]  TURN_KP_RST        = -32'sd131072;
  localparam logic [ILIM_W-1:0]         INTEGRAL_LIMIT_RST = 16'd2000;
  localparam logic signed [ANGLE_W-1:0] BALANCE_ANGLE_RST  = 17'sd0;
  localparam logic [PWM_W-1:0]          PWM_LIMIT_RST      = 15'd7200;
  localparam logic [SMAX_W-1:0]         SPEED_MAX_RST      = 7'd40;

  // Targets
  localparam int unsigned TURN_LIMIT_DEF = 350;
  localparam int unsigned TURN_STEP      = 30;
  localparam int unsigned TS_W           = 8;
  localparam logic signed [TS_W-1:0] TS_TURN = 8'sd20;

  // Datapath widths
  localparam int unsigned ERR_W  = 18;
  localparam int unsigned FE_W   = 18;
  localparam int unsigned SI_W   = 18;
  localparam int unsigned NUM_W  = 21;
  localparam int unsigned MQ_W   = 25;
  localparam int unsigned PROD_W = GAIN_W + 1 + MQ_W;
  localparam int unsigned DIV_W  = 21;
  localparam int unsigned REM_W  = 5;
  localparam int unsigned UP_W   = 34;
  localparam int unsigned TN_W   = 29;
  localparam int unsigned DRV_W  = 35;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SO_W   = 16;

  // Serial divider constants and fixed-point shifts
  localparam logic [REM_W-1:0] FE_DIV = 5'd10;
  localparam logic [REM_W-1:0] SO_DIV = 5'd25;
  localparam int unsigned SO_SHIFT     = 19;
  localparam int unsigned SO_SAT_BOUND = 819200;
  localparam int unsigned GYRO_SHIFT   = 8;
  localparam int unsigned UP_SHIFT     = 24;
  localparam int unsigned TN_SHIFT     = 16;

endpackage
`default_nettype wire

/* rtl/balance_robot_cascaded_pid.sv */
`timescale 1ns / 1ps
`default_nettype none
// Balance controller: one control tick per input word, one motor word out.
// Slave stream s_axis carries the buttons, encoder counts, roll and gyro rates;
// master stream m_axis returns the left and right motor drives. The cfg channel
// writes gain and limit registers by index and is always ready; write it only
// while no tick is in flight.
// A tick runs from acceptance to a loaded result, and no new word is taken until
// it is done: a bit-serial restoring divider (for the /10 filter and the /25 speed
// scale) and one shared shift-add multiplier that retires one multiplier bit per
// cycle (for each of four products), plus setup and handoff states.
// One tick is processed at a time; s_axis_tready is high while the sequencer is
// idle, so the next word can be taken while the previous result still waits in
// the output register. A stalled m_axis holds the result and the sequencer waits
// at its last step until the output register frees.
// Reset loads the default gains and limits and clears the filtered error,
// speed integral, target speed, target turn and the output valid.
module balance_robot_cascaded_pid #(
  parameter int unsigned TURN_LIMIT = brcp_pkg::TURN_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [brcp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [brcp_pkg::GAIN_W-1:0]        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // ahead, back, left, right, clear_integral, encoder_left, encoder_right,
  // roll_angle, gyro_x, gyro_z
  input  logic [brcp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // motor_left, motor_right
  output logic [brcp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import brcp_pkg::*;

  localparam int unsigned TT_W = $clog2(TURN_LIMIT + 1) + 1;
  localparam logic signed [TT_W:0] TLIM = (TT_W+1)'(TURN_LIMIT);
  localparam logic signed [TT_W:0] TSTEP = (TT_W+1)'(TURN_STEP);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_INT   = 4'd3;
  localparam logic [3:0] ST_LDM   = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_MDONE = 4'd6;
  localparam logic [3:0] ST_DIFF  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  localparam logic [1:0] MSEL_SPEED = 2'd0;
  localparam logic [1:0] MSEL_UPR   = 2'd1;
  localparam logic [1:0] MSEL_GYRO  = 2'd2;
  localparam logic [1:0] MSEL_TURN  = 2'd3;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MQ_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

  // Configuration registers
  logic signed [GAIN_W-1:0]  upright_kp_q, upright_kd_q, speed_kp_q, turn_kp_q;
  logic [ILIM_W-1:0]         integral_limit_q;
  logic signed [ANGLE_W-1:0] balance_angle_q;
  logic [PWM_W-1:0]          pwm_limit_q;
  logic [SMAX_W-1:0]         speed_max_q;

  // Control state
  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [1:0]               sel_q, sel_d;
  logic signed [TS_W-1:0]   ts_q, ts_d;
  logic signed [TT_W-1:0]   tt_q, tt_d;
  logic signed [FE_W-1:0]   fe_q, fe_d;
  logic signed [SI_W-1:0]   si_q, si_d;
  logic                     mval_q, mval_d;

  // Payload
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [ANGLE_W-1:0] roll_q, roll_d;
  logic signed [GYRO_W-1:0]  gx_q, gx_d;
  logic                      clr_q, clr_d;
  logic [DIV_W-1:0]          dv_q, dv_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic                      div25_q, div25_d;
  logic                      neg_q, neg_d;
  logic                      sat_q, sat_d;
  logic signed [GAIN_W-1:0]  mc_q, mc_d;
  logic [MQ_W-1:0]           mq_q, mq_d;
  logic [GAIN_W:0]           hi_q, hi_d;
  logic [MQ_W-1:0]           lo_q, lo_d;
  logic [PROD_W-1:0]         acc_q, acc_d;
  logic signed [UP_W-1:0]    up_q, up_d;
  logic signed [TN_W-1:0]    tn_q, tn_d;
  logic [OUT_TDATA_W-1:0]    mdata_q, mdata_d;

  // Input fields
  logic                      in_ahead, in_back, in_left, in_right, in_clr;
  logic signed [ENC_W-1:0]   in_enc_l, in_enc_r;
  logic signed [ANGLE_W-1:0] in_roll;
  logic signed [GYRO_W-1:0]  in_gx;

  // Combinational helpers
  logic signed [TS_W:0]     ts_a, ts_b, ts_c, smax_s;
  logic signed [TS_W-1:0]   ts_new;
  logic signed [TT_W:0]     tt_a, tt_b, tt_c;
  logic signed [NUM_W-1:0]  num_e, num_f, num;
  logic [NUM_W-1:0]         num_mag;
  logic [REM_W:0]           dv_t, dv_sub;
  logic                     dv_ge;
  logic [REM_W-1:0]         dsr;
  logic [GAIN_W:0]          mc_ext, addend, msum;
  logic signed [FE_W-1:0]   fe_new;
  logic signed [SI_W:0]     si_sum, si_c, ilim_s;
  logic signed [MQ_W-1:0]   fe25, mq_speed;
  logic [PROD_W-1:0]        prod, pmag, prod_r, acc_r;
  logic [SO_W-2:0]          so_q15;
  logic signed [SO_W-1:0]   so;
  logic signed [MQ_W-1:0]   diff;
  logic signed [DRV_W-1:0]  up_x, tn_x, ml, mr, pwm_s, ml_c, mr_c;
  logic                     out_free, in_acc;

  assign in_ahead = s_axis_tdata[0];
  assign in_back  = s_axis_tdata[1];
  assign in_left  = s_axis_tdata[2];
  assign in_right = s_axis_tdata[3];
  assign in_clr   = s_axis_tdata[4];
  assign in_enc_l = s_axis_tdata[20:5];
  assign in_enc_r = s_axis_tdata[36:21];
  assign in_roll  = s_axis_tdata[53:37];
  assign in_gx    = s_axis_tdata[69:54];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign out_free      = ~mval_q | m_axis_tready;

  // Target ramps
  always_comb begin
    ts_a   = (in_ahead | in_back) ? {ts_q[TS_W-1], ts_q} : '0;
    ts_b   = ts_a - $signed({{TS_W{1'b0}}, in_ahead}) + $signed({{TS_W{1'b0}}, in_back});
    smax_s = $signed({{(TS_W+1-SMAX_W){1'b0}}, speed_max_q});
    if (ts_b > smax_s) begin
      ts_c = smax_s;
    end else if (ts_b < -smax_s) begin
      ts_c = -smax_s;
    end else begin
      ts_c = ts_b;
    end
    ts_new = (in_left | in_right) ? TS_TURN : ts_c[TS_W-1:0];

    tt_a = (in_left | in_right) ? {tt_q[TT_W-1], tt_q} : '0;
    tt_b = tt_a + (in_left ? TSTEP : '0) - (in_right ? TSTEP : '0);
    if (tt_b > TLIM) begin
      tt_c = TLIM;
    end else if (tt_b < -TLIM) begin
      tt_c = -TLIM;
    end else begin
      tt_c = tt_b;
    end
  end

  // Shared datapath pieces
  always_comb begin
    num_e   = {{(NUM_W-ERR_W){err_q[ERR_W-1]}}, err_q};
    num_f   = {{(NUM_W-FE_W){fe_q[FE_W-1]}}, fe_q};
    num     = (num_e <<< 1) + num_e + (num_f <<< 3) - num_f;
    num_mag = num[NUM_W-1] ? -num : num;

    dsr    = div25_q ? SO_DIV : FE_DIV;
    dv_t   = {rem_q, dv_q[DIV_W-1]};
    dv_sub = dv_t - {1'b0, dsr};
    dv_ge  = (dv_t >= {1'b0, dsr});

    mc_ext = {mc_q[GAIN_W-1], mc_q};
    if (mq_q[0]) begin
      addend = (cnt_q == MUL_LAST) ? -mc_ext : mc_ext;
    end else begin
      addend = '0;
    end
    msum = hi_q + addend;

    fe_new = neg_q ? -dv_q[FE_W-1:0] : dv_q[FE_W-1:0];
    si_sum = {si_q[SI_W-1], si_q} + {fe_new[FE_W-1], fe_new};
    ilim_s = $signed({{(SI_W+1-ILIM_W){1'b0}}, integral_limit_q});
    if (si_sum > ilim_s) begin
      si_c = ilim_s;
    end else if (si_sum < -ilim_s) begin
      si_c = -ilim_s;
    end else begin
      si_c = si_sum;
    end

    fe25     = {{(MQ_W-FE_W){fe_q[FE_W-1]}}, fe_q};
    mq_speed = (fe25 <<< 7) + (fe25 <<< 6) + (fe25 <<< 3)
             + $signed({{(MQ_W-SI_W){si_q[SI_W-1]}}, si_q});

    prod   = {hi_q, lo_q};
    pmag   = prod[PROD_W-1] ? -prod : prod;
    prod_r = prod + {{(PROD_W-TN_SHIFT){1'b0}}, {TN_SHIFT{prod[PROD_W-1]}}};
    acc_r  = acc_q + {{(PROD_W-UP_SHIFT){1'b0}}, {UP_SHIFT{acc_q[PROD_W-1]}}};

    so_q15 = sat_q ? {(SO_W-1){1'b1}} : dv_q[SO_W-2:0];
    so     = neg_q ? -$signed({1'b0, so_q15}) : $signed({1'b0, so_q15});
    diff   = $signed({{(MQ_W-ANGLE_W){roll_q[ANGLE_W-1]}}, roll_q})
           + $signed({{(MQ_W-ANGLE_W){balance_angle_q[ANGLE_W-1]}}, balance_angle_q})
           - $signed({so[SO_W-1], so, 8'd0});

    up_x  = {{(DRV_W-UP_W){up_q[UP_W-1]}}, up_q};
    tn_x  = {{(DRV_W-TN_W){tn_q[TN_W-1]}}, tn_q};
    ml    = up_x - tn_x;
    mr    = up_x + tn_x;
    pwm_s = $signed({{(DRV_W-PWM_W){1'b0}}, pwm_limit_q});
    if (ml > pwm_s) begin
      ml_c = pwm_s;
    end else if (ml < -pwm_s) begin
      ml_c = -pwm_s;
    end else begin
      ml_c = ml;
    end
    if (mr > pwm_s) begin
      mr_c = pwm_s;
    end else if (mr < -pwm_s) begin
      mr_c = -pwm_s;
    end else begin
      mr_c = mr;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    ts_d    = ts_q;
    tt_d    = tt_q;
    fe_d    = fe_q;
    si_d    = si_q;
    err_d   = err_q;
    roll_d  = roll_q;
    gx_d    = gx_q;
    clr_d   = clr_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    div25_d = div25_q;
    neg_d   = neg_q;
    sat_d   = sat_q;
    mc_d    = mc_q;
    mq_d    = mq_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    acc_d   = acc_q;
    up_d    = up_q;
    tn_d    = tn_q;
    mdata_d = mdata_q;
    mval_d  = mval_q & ~m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ts_d   = ts_new;
          tt_d   = tt_c[TT_W-1:0];
          err_d  = $signed({{(ERR_W-ENC_W){in_enc_l[ENC_W-1]}}, in_enc_l})
                 + $signed({{(ERR_W-ENC_W){in_enc_r[ENC_W-1]}}, in_enc_r})
                 - $signed({{(ERR_W-TS_W){ts_new[TS_W-1]}}, ts_new});
          roll_d = in_roll;
          gx_d   = in_gx;
          clr_d  = in_clr;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        dv_d    = num_mag;
        rem_d   = '0;
        div25_d = 1'b0;
        neg_d   = num[NUM_W-1];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle, MSB first
        rem_d = dv_ge ? dv_sub[REM_W-1:0] : dv_t[REM_W-1:0];
        dv_d  = {dv_q[DIV_W-2:0], dv_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          state_d = div25_q ? ST_DIFF : ST_INT;
        end
      end
      ST_INT: begin
        fe_d    = fe_new;
        si_d    = clr_q ? '0 : si_c[SI_W-1:0];
        state_d = ST_LDM;
      end
      ST_LDM: begin
        mc_d    = speed_kp_q;
        mq_d    = mq_speed;
        hi_d    = '0;
        lo_d    = '0;
        cnt_d   = '0;
        sel_d   = MSEL_SPEED;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        hi_d  = {msum[GAIN_W], msum[GAIN_W:1]};
        lo_d  = {msum[0], lo_q[MQ_W-1:1]};
        mq_d  = {1'b0, mq_q[MQ_W-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = ST_MDONE;
        end
      end
      ST_MDONE: begin
        hi_d  = '0;
        lo_d  = '0;
        cnt_d = '0;
        case (sel_q)
          MSEL_SPEED: begin
            // magnitude over 2^19, then /25; saturate when the quotient would pass 32767
            neg_d   = prod[PROD_W-1];
            sat_d   = (pmag[PROD_W-1:SO_SHIFT] >= (PROD_W-SO_SHIFT)'(SO_SAT_BOUND));
            dv_d    = {1'b0, pmag[SO_SHIFT+DIV_W-2:SO_SHIFT]};
            rem_d   = '0;
            div25_d = 1'b1;
            state_d = ST_DIV;
          end
          MSEL_UPR: begin
            acc_d   = prod;
            mc_d    = upright_kd_q;
            mq_d    = {{(MQ_W-GYRO_W){gx_q[GYRO_W-1]}}, gx_q};
            sel_d   = MSEL_GYRO;
            state_d = ST_MUL;
          end
          MSEL_GYRO: begin
            acc_d   = acc_q + {prod[PROD_W-GYRO_SHIFT-1:0], {GYRO_SHIFT{1'b0}}};
            mc_d    = turn_kp_q;
            mq_d    = {{(MQ_W-TT_W){tt_q[TT_W-1]}}, tt_q};
            sel_d   = MSEL_TURN;
            state_d = ST_MUL;
          end
          MSEL_TURN: begin
            up_d    = acc_r[UP_SHIFT+UP_W-1:UP_SHIFT];
            tn_d    = prod_r[TN_SHIFT+TN_W-1:TN_SHIFT];
            state_d = ST_OUT;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DIFF: begin
        mc_d    = upright_kp_q;
        mq_d    = diff;
        hi_d    = '0;
        lo_d    = '0;
        cnt_d   = '0;
        sel_d   = MSEL_UPR;
        state_d = ST_MUL;
      end
      ST_OUT: begin
        // hold until the output register frees
        if (out_free) begin
          mdata_d = {mr_c[MOTOR_W-1:0], ml_c[MOTOR_W-1:0]};
          mval_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cnt_q            <= '0;
      sel_q            <= MSEL_SPEED;
      ts_q             <= '0;
      tt_q             <= '0;
      fe_q             <= '0;
      si_q             <= '0;
      mval_q           <= 1'b0;
      upright_kp_q     <= UPRIGHT_KP_RST;
      upright_kd_q     <= UPRIGHT_KD_RST;
      speed_kp_q       <= SPEED_KP_RST;
      turn_kp_q        <= TURN_KP_RST;
      integral_limit_q <= INTEGRAL_LIMIT_RST;
      balance_angle_q  <= BALANCE_ANGLE_RST;
      pwm_limit_q      <= PWM_LIMIT_RST;
      speed_max_q      <= SPEED_MAX_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      ts_q    <= ts_d;
      tt_q    <= tt_d;
      fe_q    <= fe_d;
      si_q    <= si_d;
      mval_q  <= mval_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_UPRIGHT_KP:     upright_kp_q     <= cfg_data_i;
          REG_UPRIGHT_KD:     upright_kd_q     <= cfg_data_i;
          REG_SPEED_KP:       speed_kp_q       <= cfg_data_i;
          REG_TURN_KP:        turn_kp_q        <= cfg_data_i;
          REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[ILIM_W-1:0];
          REG_BALANCE_ANGLE:  balance_angle_q  <= cfg_data_i[ANGLE_W-1:0];
          REG_PWM_LIMIT:      pwm_limit_q      <= cfg_data_i[PWM_W-1:0];
          REG_SPEED_MAX:      speed_max_q      <= cfg_data_i[SMAX_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    roll_q  <= roll_d;
    gx_q    <= gx_d;
    clr_q   <= clr_d;
    dv_q    <= dv_d;
    rem_q   <= rem_d;
    div25_q <= div25_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    mc_q    <= mc_d;
    mq_q    <= mq_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    acc_q   <= acc_d;
    up_q    <= up_d;
    tn_q    <= tn_d;
    mdata_q <= mdata_d;
  end

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;
  import brcp_pkg::*;

  localparam int unsigned TURN_LIM = 350;
  localparam int TAIL_CYC = 200;
  localparam int HOLD_CYC = 400;

  typedef struct packed {
    bit                 ahead;
    bit                 back;
    bit                 go_left;
    bit                 go_right;
    bit                 clr;
    logic signed [15:0] enc_l;
    logic signed [15:0] enc_r;
    logic signed [16:0] roll;
    logic signed [15:0] gx;
    logic signed [15:0] gz;
  } tick_t;

  typedef struct packed {
    logic [15:0] ml;
    logic [15:0] mr;
  } drive_pair_t;

  // known = 1: the drive values in the row are checked as typed
  typedef struct packed {
    bit                 ahead;
    bit                 back;
    bit                 go_left;
    bit                 go_right;
    bit                 clr;
    logic signed [15:0] enc_l;
    logic signed [15:0] enc_r;
    logic signed [16:0] roll;
    logic signed [15:0] gx;
    logic signed [15:0] gz;
    bit                 known;
    logic signed [15:0] ml;
    logic signed [15:0] mr;
  } dir_row_t;

  localparam int DIR_N = 22;
  localparam dir_row_t DIR_TBL [DIR_N] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 46080, 0, 0, 1, -7200, -7200},
    '{0, 0, 0, 0, 0, 0, 0, -46080, 0, 0, 1, 7200, 7200},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 32767, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, -32768, 0, 0, 0, 0},
    // gyro z must not move the drives
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 1, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, -32768, 1, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 1000, 1000, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 32767, 32767, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, -32768, -32768, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 32767, -32768, 0, 0, 0, 0, 0, 0},
    '{1, 1, 1, 1, 1, -1, -1, -1, -1, -1, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [GAIN_W-1:0]      cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // controller registers and state as the block should hold them
  logic signed [GAIN_W-1:0]  r_up_kp, r_up_kd, r_speed_kp, r_turn_kp;
  logic [ILIM_W-1:0]         r_ilim;
  logic signed [ANGLE_W-1:0] r_bal;
  logic [PWM_W-1:0]          r_pwm;
  logic [SMAX_W-1:0]         r_smax;
  longint filt_err, spd_int, tgt_speed, tgt_turn;

  drive_pair_t motor_q [$];
  int  bad_count = 0;
  int  rx_count = 0;
  int  hold_at = 60;
  int  hold_left = 0;
  bit  no_idle = 1'b0;
  logic [3:0] held_btn = 4'd0;
  int  run_left = 0;

  always #10 clk = ~clk;

  balance_robot_cascaded_pid #(
    .TURN_LIMIT(TURN_LIM)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic drive_pair_t predict_drives(tick_t t);
    longint err, speed_out, diff, upright, turn;
    drive_pair_t d;
    if (!t.ahead && !t.back) tgt_speed = 0;
    if (t.ahead) tgt_speed -= 1;
    if (t.back) tgt_speed += 1;
    tgt_speed = clamp_mag(tgt_speed, longint'(r_smax));
    if (!t.go_left && !t.go_right) tgt_turn = 0;
    if (t.go_left) begin
      tgt_turn += 30;
      tgt_speed = 20;
    end
    if (t.go_right) begin
      tgt_turn -= 30;
      tgt_speed = 20;
    end
    tgt_turn = clamp_mag(tgt_turn, longint'(TURN_LIM));

    err = longint'(t.enc_l) + longint'(t.enc_r) - tgt_speed;
    filt_err = (3 * err + 7 * filt_err) / 10;
    spd_int = clamp_mag(spd_int + filt_err, longint'(r_ilim));
    if (t.clr) spd_int = 0;

    speed_out = (longint'(r_speed_kp) * (200 * filt_err + spd_int)) / 64'sd13107200;
    speed_out = clamp_mag(speed_out, 32767);
    diff = longint'(t.roll) + longint'(r_bal) - speed_out * 256;
    upright = (longint'(r_up_kp) * diff + longint'(r_up_kd) * longint'(t.gx) * 256)
              / 64'sd16777216;
    turn = (longint'(r_turn_kp) * tgt_turn) / 64'sd65536;

    d.ml = 16'(clamp_mag(upright - turn, longint'(r_pwm)));
    d.mr = 16'(clamp_mag(upright + turn, longint'(r_pwm)));
    return d;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_tick(tick_t t);
    return {2'b00, t.gz, t.gx, t.roll, t.enc_r, t.enc_l,
            t.clr, t.go_right, t.go_left, t.back, t.ahead};
  endfunction

  // buttons are held for runs so the targets ramp into their clamps
  function automatic tick_t rand_tick();
    tick_t t;
    logic [3:0] btn;
    if (run_left == 0) begin
      held_btn = 4'($urandom_range(15));
      run_left = $urandom_range(1, 25);
    end
    run_left--;
    btn = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : held_btn;
    {t.go_right, t.go_left, t.back, t.ahead} = btn;
    t.clr = ($urandom_range(19) == 0);
    if ($urandom_range(4) == 0) begin
      t.enc_l = 16'($urandom());
      t.enc_r = 16'($urandom());
    end else begin
      t.enc_l = 16'($urandom_range(600) - 300);
      t.enc_r = 16'($urandom_range(600) - 300);
    end
    if ($urandom_range(4) == 0) t.roll = 17'($urandom_range(92160) - 46080);
    else t.roll = 17'($urandom_range(6000) - 3000);
    if ($urandom_range(4) == 0) t.gx = 16'($urandom());
    else t.gx = 16'($urandom_range(4000) - 2000);
    t.gz = 16'($urandom());
    return t;
  endfunction

  function automatic void note_bad(string msg);
    bad_count++;
    if (bad_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_UPRIGHT_KP:     r_up_kp = val;
      REG_UPRIGHT_KD:     r_up_kd = val;
      REG_SPEED_KP:       r_speed_kp = val;
      REG_TURN_KP:        r_turn_kp = val;
      REG_INTEGRAL_LIMIT: r_ilim = val[ILIM_W-1:0];
      REG_BALANCE_ANGLE:  r_bal = val[ANGLE_W-1:0];
      REG_PWM_LIMIT:      r_pwm = val[PWM_W-1:0];
      REG_SPEED_MAX:      r_smax = val[SMAX_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_regs(logic [31:0] up_kp, logic [31:0] up_kd, logic [31:0] sp_kp,
                           logic [31:0] tn_kp, logic [31:0] ilim, logic [31:0] bal,
                           logic [31:0] pwm, logic [31:0] smax);
    cfg_write(REG_UPRIGHT_KP, up_kp);
    cfg_write(REG_UPRIGHT_KD, up_kd);
    cfg_write(REG_SPEED_KP, sp_kp);
    cfg_write(REG_TURN_KP, tn_kp);
    cfg_write(REG_INTEGRAL_LIMIT, ilim);
    cfg_write(REG_BALANCE_ANGLE, bal);
    cfg_write(REG_PWM_LIMIT, pwm);
    cfg_write(REG_SPEED_MAX, smax);
  endtask

  task automatic send_tick(tick_t t);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_tick(t);
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic run_random(int n);
    tick_t t;
    repeat (n) begin
      t = rand_tick();
      send_tick(t);
      motor_q.push_back(predict_drives(t));
    end
  endtask

  // wait out the tick in flight before touching the registers
  task automatic drain_block();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (motor_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  initial begin
    tick_t t;
    drive_pair_t d;
    rst_n         = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_UPRIGHT_KP;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    r_up_kp    = UPRIGHT_KP_RST;
    r_up_kd    = UPRIGHT_KD_RST;
    r_speed_kp = SPEED_KP_RST;
    r_turn_kp  = TURN_KP_RST;
    r_ilim     = INTEGRAL_LIMIT_RST;
    r_bal      = BALANCE_ANGLE_RST;
    r_pwm      = PWM_LIMIT_RST;
    r_smax     = SPEED_MAX_RST;
    filt_err  = 0;
    spd_int   = 0;
    tgt_speed = 0;
    tgt_turn  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      t = '{DIR_TBL[i].ahead, DIR_TBL[i].back, DIR_TBL[i].go_left, DIR_TBL[i].go_right,
            DIR_TBL[i].clr, DIR_TBL[i].enc_l, DIR_TBL[i].enc_r, DIR_TBL[i].roll,
            DIR_TBL[i].gx, DIR_TBL[i].gz};
      send_tick(t);
      d = predict_drives(t);
      if (DIR_TBL[i].known) d = '{DIR_TBL[i].ml, DIR_TBL[i].mr};
      motor_q.push_back(d);
    end
    run_random(150);
    drain_block();

    load_regs(-8000000, -120000, 60000, -200000, 0, 46080, 32767, 127);
    no_idle = 1'b1;
    run_random(80);
    no_idle = 1'b0;
    run_random(80);
    drain_block();

    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              65535, -46080, 0, 0);
    run_random(120);
    drain_block();

    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              65535, 0, 32767, 127);
    run_random(120);
    drain_block();

    repeat (2) begin
      load_regs($urandom_range(40000000) - 20000000, $urandom_range(400000) - 200000,
                $urandom_range(200000) - 100000, $urandom_range(800000) - 400000,
                $urandom_range(65535), $urandom_range(92160) - 46080,
                $urandom_range(32767), $urandom_range(127));
      run_random(130);
      drain_block();
    end

    if (motor_q.size() != 0) note_bad("results still pending at end of run");
    if (bad_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver side: random stalls plus long hold-offs to back up the block
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_count >= hold_at) begin
        m_axis_tready <= 1'b0;
        hold_left = HOLD_CYC;
        hold_at += 400;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  always @(posedge clk) begin
    drive_pair_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      rx_count++;
      if (motor_q.size() == 0) begin
        note_bad($sformatf("unexpected word %h", m_axis_tdata));
      end else begin
        want = motor_q.pop_front();
        if (m_axis_tdata[15:0] !== want.ml)
          note_bad($sformatf("word %0d motor_left exp %0d got %0d", rx_count,
                             $signed(want.ml), $signed(m_axis_tdata[15:0])));
        if (m_axis_tdata[31:16] !== want.mr)
          note_bad($sformatf("word %0d motor_right exp %0d got %0d", rx_count,
                             $signed(want.mr), $signed(m_axis_tdata[31:16])));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
